[sv/tqprs_pkg.sv]
`default_nettype none

package tqprs_pkg;

	// Action codes carried by an input beat
	localparam logic [1:0] ACT_LAND_REQ    = 2'd0;
	localparam logic [1:0] ACT_TAKEOFF_REQ = 2'd1;
	localparam logic [1:0] ACT_TICK        = 2'd2;

	// Status codes carried by a result beat
	localparam logic [2:0] ST_ACCEPTED = 3'd0;
	localparam logic [2:0] ST_REFUSED  = 3'd1;
	localparam logic [2:0] ST_LANDED   = 3'd2;
	localparam logic [2:0] ST_TOOKOFF  = 3'd3;
	localparam logic [2:0] ST_IDLE     = 3'd4;
	localparam logic [2:0] ST_DROPPED  = 3'd5;

	// Queue slot layouts
	typedef struct packed {
		logic [31:0] arrival;
		logic [15:0] flight;
		logic [7:0]  fuel;
	} landing_entry_t;

	typedef struct packed {
		logic [31:0] arrival;
		logic [15:0] flight;
	} takeoff_entry_t;

endpackage

`default_nettype wire

[sv/tqprs_ram.sv]
`default_nettype none

module tqprs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write one word, read one word with registered data (old data on collision)
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[sv/two_queue_priority_runway_scheduler.sv]
`default_nettype none
// An accepted input beat passes the input register, then the result register, and waits
//   in the input register while a stalled result beat holds the result register.
// Throughput: one item per cycle while the result is not stalled; the queue head is prefetched from each queue RAM.
// Reset (arst_n low): both queues empty, all statistics zero, occupancy limit 16,
//   no beat pending. Queue RAM contents are not cleared and need no clearing pass.

module two_queue_priority_runway_scheduler #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        occupancy_limit_we,
	input  wire logic [4:0]  occupancy_limit_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  action,
	input  wire logic [31:0] now,
	input  wire logic [15:0] flight_id,
	input  wire logic [7:0]  fuel_left,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [15:0]      served_flight,
	output logic [31:0]      wait_time,
	output logic [4:0]       landing_occupancy,
	output logic [4:0]       takeoff_occupancy,
	output logic [31:0]      landings_total,
	output logic [31:0]      takeoffs_total,
	output logic [31:0]      landing_refused_total,
	output logic [31:0]      takeoff_refused_total,
	output logic [31:0]      dropped_total,
	output logic [31:0]      landing_wait_sum,
	output logic [31:0]      takeoff_wait_sum
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int LW = (CW > 5) ? CW : 5;
	localparam int LWID = $bits(tqprs_pkg::landing_entry_t);
	localparam int TWID = $bits(tqprs_pkg::takeoff_entry_t);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
	localparam logic [AW:0]   DEPTH_S = (AW + 1)'(QUEUE_DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);

	// Input register
	logic        valid_s1;
	logic [1:0]  action_s1;
	logic [31:0] now_s1;
	logic [15:0] flight_s1;
	logic [7:0]  fuel_s1;

	// Queue and configuration state
	logic [4:0]    limit_q;
	logic [AW-1:0] l_head_q, t_head_q;
	logic [CW-1:0] l_count_q, t_count_q;
	logic          l_byp_q, t_byp_q;
	tqprs_pkg::landing_entry_t l_byp_data_q;
	tqprs_pkg::takeoff_entry_t t_byp_data_q;

	// Statistics
	logic [31:0] landings_q, takeoffs_q, l_refused_q, t_refused_q;
	logic [31:0] dropped_q, l_wait_q, t_wait_q;

	// Result register
	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [15:0] served_q;
	logic [31:0] wait_q;

	logic fire, take_in;
	logic is_lreq, is_treq, is_tick;
	logic [LW-1:0] l_cnt_ext, t_cnt_ext, limit_ext;
	logic l_full, t_full;
	logic l_push, t_push, l_refuse, t_refuse, l_pop, t_pop;
	logic [AW:0]   l_tail_sum, t_tail_sum, l_tail_w, t_tail_w;
	logic [AW-1:0] l_tail, t_tail, l_head_nx, t_head_nx, l_raddr, t_raddr;
	logic [LWID-1:0] l_rdata;
	logic [TWID-1:0] t_rdata;
	tqprs_pkg::landing_entry_t l_head_ent, l_wdata;
	tqprs_pkg::takeoff_entry_t t_head_ent, t_wdata;
	logic [31:0] l_wait, t_wait;
	logic        l_drop;
	logic [2:0]  status_nx;
	logic [15:0] served_nx;
	logic [31:0] wait_nx;

	// Handshake: the input stage moves whenever the result register can load
	assign fire     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !fire;
	assign take_in  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture input beat
	always_ff @(posedge clk) begin
		if (take_in) begin
			action_s1 <= action;
			now_s1    <= now;
			flight_s1 <= flight_id;
			fuel_s1   <= fuel_left;
		end
	end

	// Decode action and admission
	assign is_lreq = action_s1 == tqprs_pkg::ACT_LAND_REQ;
	assign is_treq = action_s1 == tqprs_pkg::ACT_TAKEOFF_REQ;
	assign is_tick = action_s1 == tqprs_pkg::ACT_TICK;

	assign l_cnt_ext = LW'(l_count_q);
	assign t_cnt_ext = LW'(t_count_q);
	assign limit_ext = LW'(limit_q);
	assign l_full    = (l_cnt_ext >= limit_ext) || (l_count_q == DEPTH_C);
	assign t_full    = (t_cnt_ext >= limit_ext) || (t_count_q == DEPTH_C);

	assign l_push   = fire && is_lreq && !l_full;
	assign l_refuse = fire && is_lreq && l_full;
	assign t_push   = fire && is_treq && !t_full;
	assign t_refuse = fire && is_treq && t_full;
	assign l_pop    = fire && is_tick && (l_count_q != '0);
	assign t_pop    = fire && is_tick && (l_count_q == '0) && (t_count_q != '0);

	// Tail slot: head plus count, wrapped once at the depth
	assign l_tail_sum = (AW + 1)'(l_head_q) + (AW + 1)'(l_count_q);
	assign t_tail_sum = (AW + 1)'(t_head_q) + (AW + 1)'(t_count_q);
	assign l_tail_w   = (l_tail_sum >= DEPTH_S) ? l_tail_sum - DEPTH_S : l_tail_sum;
	assign t_tail_w   = (t_tail_sum >= DEPTH_S) ? t_tail_sum - DEPTH_S : t_tail_sum;
	assign l_tail     = l_tail_w[AW-1:0];
	assign t_tail     = t_tail_w[AW-1:0];

	// Advance head with wrap
	assign l_head_nx = (l_head_q == LAST_IDX) ? '0 : l_head_q + 1'b1;
	assign t_head_nx = (t_head_q == LAST_IDX) ? '0 : t_head_q + 1'b1;

	// Prefetch the head slot that holds after this cycle
	assign l_raddr = l_pop ? l_head_nx : l_head_q;
	assign t_raddr = t_pop ? t_head_nx : t_head_q;

	assign l_wdata = '{arrival: now_s1, flight: flight_s1, fuel: fuel_s1};
	assign t_wdata = '{arrival: now_s1, flight: flight_s1};

	tqprs_ram #(
		.WIDTH(LWID),
		.DEPTH(QUEUE_DEPTH)
	) u_landing_ram (
		.clk  (clk),
		.we   (l_push),
		.waddr(l_tail),
		.wdata(l_wdata),
		.raddr(l_raddr),
		.rdata(l_rdata)
	);

	tqprs_ram #(
		.WIDTH(TWID),
		.DEPTH(QUEUE_DEPTH)
	) u_takeoff_ram (
		.clk  (clk),
		.we   (t_push),
		.waddr(t_tail),
		.wdata(t_wdata),
		.raddr(t_raddr),
		.rdata(t_rdata)
	);

	// Bypass a write that lands on the slot being prefetched
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l_byp_q <= 1'b0;
			t_byp_q <= 1'b0;
		end else begin
			l_byp_q <= l_push && (l_tail == l_raddr);
			t_byp_q <= t_push && (t_tail == t_raddr);
		end
	end

	always_ff @(posedge clk) begin
		l_byp_data_q <= l_wdata;
		t_byp_data_q <= t_wdata;
	end

	assign l_head_ent = l_byp_q ? l_byp_data_q : tqprs_pkg::landing_entry_t'(l_rdata);
	assign t_head_ent = t_byp_q ? t_byp_data_q : tqprs_pkg::takeoff_entry_t'(t_rdata);

	assign l_wait = now_s1 - l_head_ent.arrival;
	assign t_wait = now_s1 - t_head_ent.arrival;
	assign l_drop = l_head_ent.fuel == '0;

	// Form the result beat
	always_comb begin
		status_nx = tqprs_pkg::ST_REFUSED;
		served_nx = '0;
		wait_nx   = '0;
		unique case (action_s1)
			tqprs_pkg::ACT_LAND_REQ: begin
				status_nx = l_full ? tqprs_pkg::ST_REFUSED : tqprs_pkg::ST_ACCEPTED;
			end
			tqprs_pkg::ACT_TAKEOFF_REQ: begin
				status_nx = t_full ? tqprs_pkg::ST_REFUSED : tqprs_pkg::ST_ACCEPTED;
			end
			tqprs_pkg::ACT_TICK: begin
				if (l_count_q != '0) begin
					status_nx = l_drop ? tqprs_pkg::ST_DROPPED : tqprs_pkg::ST_LANDED;
					served_nx = l_head_ent.flight;
					wait_nx   = l_wait;
				end else if (t_count_q != '0) begin
					status_nx = tqprs_pkg::ST_TOOKOFF;
					served_nx = t_head_ent.flight;
					wait_nx   = t_wait;
				end else begin
					status_nx = tqprs_pkg::ST_IDLE;
				end
			end
			default: begin
				status_nx = tqprs_pkg::ST_REFUSED;
			end
		endcase
	end

	// Update queue pointers and the limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q   <= 5'd16;
			l_head_q  <= '0;
			t_head_q  <= '0;
			l_count_q <= '0;
			t_count_q <= '0;
		end else begin
			if (occupancy_limit_we) begin
				limit_q <= occupancy_limit_wdata;
			end
			if (l_push) begin
				l_count_q <= l_count_q + 1'b1;
			end else if (l_pop) begin
				l_count_q <= l_count_q - 1'b1;
				l_head_q  <= l_head_nx;
			end
			if (t_push) begin
				t_count_q <= t_count_q + 1'b1;
			end else if (t_pop) begin
				t_count_q <= t_count_q - 1'b1;
				t_head_q  <= t_head_nx;
			end
		end
	end

	// Accumulate statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			landings_q  <= '0;
			takeoffs_q  <= '0;
			l_refused_q <= '0;
			t_refused_q <= '0;
			dropped_q   <= '0;
			l_wait_q    <= '0;
			t_wait_q    <= '0;
		end else begin
			if (l_refuse) begin
				l_refused_q <= l_refused_q + 1'b1;
			end
			if (t_refuse) begin
				t_refused_q <= t_refused_q + 1'b1;
			end
			if (l_pop) begin
				landings_q <= landings_q + 1'b1;
				l_wait_q   <= l_wait_q + l_wait;
				if (l_drop) begin
					dropped_q <= dropped_q + 1'b1;
				end
			end
			if (t_pop) begin
				takeoffs_q <= takeoffs_q + 1'b1;
				t_wait_q   <= t_wait_q + t_wait;
			end
		end
	end

	// Result register: load on fire, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= status_nx;
			served_q <= served_nx;
			wait_q   <= wait_nx;
		end
	end

	// State changes only when a result loads, so it is the result itself
	assign out_valid             = out_valid_q;
	assign status                = status_q;
	assign served_flight         = served_q;
	assign wait_time             = wait_q;
	assign landing_occupancy     = l_cnt_ext[4:0];
	assign takeoff_occupancy     = t_cnt_ext[4:0];
	assign landings_total        = landings_q;
	assign takeoffs_total        = takeoffs_q;
	assign landing_refused_total = l_refused_q;
	assign takeoff_refused_total = t_refused_q;
	assign dropped_total         = dropped_q;
	assign landing_wait_sum      = l_wait_q;
	assign takeoff_wait_sum      = t_wait_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(l_count_q <= DEPTH_C) && (t_count_q <= DEPTH_C))
		else $error("queue count above depth");

	a_land_pop: assert property (@(posedge clk) disable iff (!arst_n)
		l_pop |=> (l_count_q == $past(l_count_q) - 1'b1) && $stable(t_count_q))
		else $error("landing pop did not shrink only the landing queue");

	a_refuse_hold: assert property (@(posedge clk) disable iff (!arst_n)
		l_refuse |=> $stable(l_count_q) && (l_refused_q == $past(l_refused_q) + 1'b1))
		else $error("refused landing changed the queue or missed the count");

	a_drop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(l_pop && l_drop) |=> (dropped_q == $past(dropped_q) + 1'b1)
			&& (status_q == tqprs_pkg::ST_DROPPED))
		else $error("dropped landing not reported or counted");

	a_push_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!((l_push || t_push) && (l_pop || t_pop)) && !(l_pop && t_pop))
		else $error("queue push and pop in one cycle");

endmodule

`default_nettype wire

[tb/tb_two_queue_priority_runway_scheduler.sv]
`default_nettype none

module tb_two_queue_priority_runway_scheduler;

	localparam int          DEPTH       = 16;
	localparam logic [1:0]  ACT_UNUSED  = 2'd3;
	localparam int          CYCLE_LIMIT = 400000;
	localparam int          PHASES      = 7;
	localparam int          PHASE_ITEMS = 215;
	localparam int          HOLD_CYCLES = 120;
	localparam int          N_ROWS      = 24;

	typedef struct {
		logic [2:0]  status;
		logic [15:0] served_flight;
		logic [31:0] wait_time;
		logic [4:0]  landing_occupancy;
		logic [4:0]  takeoff_occupancy;
		logic [31:0] landings_total;
		logic [31:0] takeoffs_total;
		logic [31:0] landing_refused_total;
		logic [31:0] takeoff_refused_total;
		logic [31:0] dropped_total;
		logic [31:0] landing_wait_sum;
		logic [31:0] takeoff_wait_sum;
	} runway_result_t;

	typedef struct {
		bit          cfg_we;
		logic [4:0]  cfg_val;
		logic [1:0]  act;
		logic [31:0] t;
		logic [15:0] flight;
		logic [7:0]  fuel;
		bit          typed;
		logic [2:0]  st;
		logic [15:0] served;
		logic [31:0] wt;
	} runway_row_t;

	// DUT signals
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        occupancy_limit_we = 1'b0;
	logic [4:0]  occupancy_limit_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  action = '0;
	logic [31:0] now = '0;
	logic [15:0] flight_id = '0;
	logic [7:0]  fuel_left = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [15:0] served_flight;
	logic [31:0] wait_time;
	logic [4:0]  landing_occupancy;
	logic [4:0]  takeoff_occupancy;
	logic [31:0] landings_total;
	logic [31:0] takeoffs_total;
	logic [31:0] landing_refused_total;
	logic [31:0] takeoff_refused_total;
	logic [31:0] dropped_total;
	logic [31:0] landing_wait_sum;
	logic [31:0] takeoff_wait_sum;

	// Scheduler shadow state
	tqprs_pkg::landing_entry_t landing_slots [DEPTH];
	tqprs_pkg::takeoff_entry_t takeoff_slots [DEPTH];
	logic [3:0]  land_head = '0;
	logic [4:0]  land_count = '0;
	logic [3:0]  dep_head = '0;
	logic [4:0]  dep_count = '0;
	logic [4:0]  limit_shadow = 5'd16;
	logic [31:0] cnt_landings = '0;
	logic [31:0] cnt_takeoffs = '0;
	logic [31:0] cnt_land_refused = '0;
	logic [31:0] cnt_dep_refused = '0;
	logic [31:0] cnt_dropped = '0;
	logic [31:0] sum_land_wait = '0;
	logic [31:0] sum_dep_wait = '0;

	runway_result_t pending_results [$];
	runway_result_t rx_beat;
	runway_row_t    plan [N_ROWS];

	int  fail_count = 0;
	int  cycle_count = 0;
	bit  idle_on = 1'b1;
	bit  rx_hold_req = 1'b0;
	int  rx_hold_left = 0;
	logic [31:0] clock_base;

	two_queue_priority_runway_scheduler #(.QUEUE_DEPTH(DEPTH)) uut (
		.clk                   (clk),
		.arst_n                (arst_n),
		.occupancy_limit_we    (occupancy_limit_we),
		.occupancy_limit_wdata (occupancy_limit_wdata),
		.in_valid              (in_valid),
		.in_stall              (in_stall),
		.action                (action),
		.now                   (now),
		.flight_id             (flight_id),
		.fuel_left             (fuel_left),
		.out_valid             (out_valid),
		.out_stall             (out_stall),
		.status                (status),
		.served_flight         (served_flight),
		.wait_time             (wait_time),
		.landing_occupancy     (landing_occupancy),
		.takeoff_occupancy     (takeoff_occupancy),
		.landings_total        (landings_total),
		.takeoffs_total        (takeoffs_total),
		.landing_refused_total (landing_refused_total),
		.takeoff_refused_total (takeoff_refused_total),
		.dropped_total         (dropped_total),
		.landing_wait_sum      (landing_wait_sum),
		.takeoff_wait_sum      (takeoff_wait_sum)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Advance the shadow scheduler by one request or tick and return its answer
	function automatic runway_result_t runway_schedule(input logic [1:0] a,
			input logic [31:0] t, input logic [15:0] f, input logic [7:0] fu);
		runway_result_t r;
		tqprs_pkg::landing_entry_t le;
		tqprs_pkg::takeoff_entry_t te;
		logic [3:0]     tail;
		r = '{default: '0};
		r.status = tqprs_pkg::ST_REFUSED;
		case (a)
			tqprs_pkg::ACT_LAND_REQ: begin
				if (land_count < limit_shadow && land_count < 5'(DEPTH)) begin
					tail = land_head + land_count[3:0];
					landing_slots[tail] = '{arrival: t, flight: f, fuel: fu};
					land_count++;
					r.status = tqprs_pkg::ST_ACCEPTED;
				end else begin
					cnt_land_refused++;
				end
			end
			tqprs_pkg::ACT_TAKEOFF_REQ: begin
				if (dep_count < limit_shadow && dep_count < 5'(DEPTH)) begin
					tail = dep_head + dep_count[3:0];
					takeoff_slots[tail] = '{arrival: t, flight: f};
					dep_count++;
					r.status = tqprs_pkg::ST_ACCEPTED;
				end else begin
					cnt_dep_refused++;
				end
			end
			tqprs_pkg::ACT_TICK: begin
				// Landings always win the runway
				if (land_count != 0) begin
					le = landing_slots[land_head];
					land_head++;
					land_count--;
					r.served_flight = le.flight;
					r.wait_time = t - le.arrival;
					sum_land_wait += r.wait_time;
					cnt_landings++;
					if (le.fuel == 8'd0) begin
						cnt_dropped++;
						r.status = tqprs_pkg::ST_DROPPED;
					end else begin
						r.status = tqprs_pkg::ST_LANDED;
					end
				end else if (dep_count != 0) begin
					te = takeoff_slots[dep_head];
					dep_head++;
					dep_count--;
					r.served_flight = te.flight;
					r.wait_time = t - te.arrival;
					sum_dep_wait += r.wait_time;
					cnt_takeoffs++;
					r.status = tqprs_pkg::ST_TOOKOFF;
				end else begin
					r.status = tqprs_pkg::ST_IDLE;
				end
			end
			default: ;
		endcase
		r.landing_occupancy = land_count;
		r.takeoff_occupancy = dep_count;
		r.landings_total = cnt_landings;
		r.takeoffs_total = cnt_takeoffs;
		r.landing_refused_total = cnt_land_refused;
		r.takeoff_refused_total = cnt_dep_refused;
		r.dropped_total = cnt_dropped;
		r.landing_wait_sum = sum_land_wait;
		r.takeoff_wait_sum = sum_dep_wait;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			fail_count++;
		end
	endfunction

	// Offer one beat with a random gap before it, hold it until accepted
	task automatic send_beat(input logic [1:0] a, input logic [31:0] t, input logic [15:0] f,
			input logic [7:0] fu, input bit typed, input logic [2:0] st,
			input logic [15:0] served, input logic [31:0] wt);
		runway_result_t r;
		if (idle_on && $urandom_range(99) < 35) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while (idle_on && $urandom_range(99) < 35)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= a;
		now <= t;
		flight_id <= f;
		fuel_left <= fu;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		r = runway_schedule(a, t, f, fu);
		if (typed) begin
			r.status = st;
			r.served_flight = served;
			r.wait_time = wt;
		end
		pending_results.push_back(r);
	endtask

	// Drop valid and wait until every result beat is back and the pipe is empty
	task automatic finish_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_limit(input logic [4:0] v);
		finish_results();
		occupancy_limit_we <= 1'b1;
		occupancy_limit_wdata <= v;
		@(posedge clk);
		occupancy_limit_we <= 1'b0;
		limit_shadow = v;
	endtask

	// Draw one random item; regime biases toward filling, draining or balance
	task automatic send_random(input int regime);
		int          pick;
		int          land_pct;
		int          dep_pct;
		logic [1:0]  a;
		logic [31:0] t;
		pick = $urandom_range(99);
		land_pct = (regime == 0) ? 40 : (regime == 1) ? 15 : 30;
		dep_pct = land_pct + ((regime == 0) ? 38 : (regime == 1) ? 15 : 30);
		if (pick < land_pct)
			a = tqprs_pkg::ACT_LAND_REQ;
		else if (pick < dep_pct)
			a = tqprs_pkg::ACT_TAKEOFF_REQ;
		else if (pick < 97)
			a = tqprs_pkg::ACT_TICK;
		else
			a = ACT_UNUSED;
		clock_base += $urandom_range(50);
		t = ($urandom_range(19) == 0) ? $urandom : clock_base;
		send_beat(a, t, 16'($urandom), ($urandom_range(4) == 0) ? 8'd0 : 8'($urandom),
			1'b0, '0, '0, '0);
	endtask

	// Check result beats in order and drive the receiver stall
	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_stall == 1'b0) begin
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected");
				fail_count++;
			end else begin
				rx_beat = pending_results.pop_front();
				check_field("status", 32'(rx_beat.status), 32'(status));
				check_field("served_flight", 32'(rx_beat.served_flight), 32'(served_flight));
				check_field("wait_time", rx_beat.wait_time, wait_time);
				check_field("landing_occupancy", 32'(rx_beat.landing_occupancy),
					32'(landing_occupancy));
				check_field("takeoff_occupancy", 32'(rx_beat.takeoff_occupancy),
					32'(takeoff_occupancy));
				check_field("landings_total", rx_beat.landings_total, landings_total);
				check_field("takeoffs_total", rx_beat.takeoffs_total, takeoffs_total);
				check_field("landing_refused_total", rx_beat.landing_refused_total,
					landing_refused_total);
				check_field("takeoff_refused_total", rx_beat.takeoff_refused_total,
					takeoff_refused_total);
				check_field("dropped_total", rx_beat.dropped_total, dropped_total);
				check_field("landing_wait_sum", rx_beat.landing_wait_sum, landing_wait_sum);
				check_field("takeoff_wait_sum", rx_beat.takeoff_wait_sum, takeoff_wait_sum);
			end
		end
		if (rx_hold_req) begin
			rx_hold_left = HOLD_CYCLES;
			rx_hold_req = 1'b0;
		end
		if (rx_hold_left > 0) begin
			out_stall <= 1'b1;
			rx_hold_left--;
		end else begin
			out_stall <= idle_on && ($urandom_range(99) < 35);
		end
	end

	initial begin
		plan[0]  = '{0, 0, tqprs_pkg::ACT_TICK, 0, 0, 0,
			1, tqprs_pkg::ST_IDLE, 0, 0};
		plan[1]  = '{0, 0, ACT_UNUSED, 32'hFFFFFFFF, 16'hFFFF, 8'hFF,
			1, tqprs_pkg::ST_REFUSED, 0, 0};
		plan[2]  = '{0, 0, tqprs_pkg::ACT_LAND_REQ, 32'hFFFFFFF0, 16'hFFFF, 8'h00,
			1, tqprs_pkg::ST_ACCEPTED, 0, 0};
		plan[3]  = '{0, 0, tqprs_pkg::ACT_TAKEOFF_REQ, 32'hFFFFFFFF, 16'h0000, 8'hFF,
			1, tqprs_pkg::ST_ACCEPTED, 0, 0};
		plan[4]  = '{0, 0, tqprs_pkg::ACT_TICK, 32'h10, 0, 0,
			1, tqprs_pkg::ST_DROPPED, 16'hFFFF, 32'h20};
		plan[5]  = '{0, 0, tqprs_pkg::ACT_TICK, 0, 0, 0,
			1, tqprs_pkg::ST_TOOKOFF, 0, 1};
		plan[6]  = '{0, 0, tqprs_pkg::ACT_TICK, 5, 0, 0,
			1, tqprs_pkg::ST_IDLE, 0, 0};
		plan[7]  = '{0, 0, tqprs_pkg::ACT_LAND_REQ, 100, 16'h1234, 8'd1,
			0, 0, 0, 0};
		plan[8]  = '{0, 0, tqprs_pkg::ACT_TAKEOFF_REQ, 101, 16'h5678, 8'd0,
			0, 0, 0, 0};
		plan[9]  = '{0, 0, tqprs_pkg::ACT_LAND_REQ, 102, 16'hABCD, 8'hFF,
			0, 0, 0, 0};
		plan[10] = '{0, 0, tqprs_pkg::ACT_TICK, 110, 0, 0,
			1, tqprs_pkg::ST_LANDED, 16'h1234, 10};
		plan[11] = '{0, 0, tqprs_pkg::ACT_TICK, 120, 0, 0,
			1, tqprs_pkg::ST_LANDED, 16'hABCD, 18};
		plan[12] = '{0, 0, tqprs_pkg::ACT_TICK, 130, 0, 0,
			1, tqprs_pkg::ST_TOOKOFF, 16'h5678, 29};
		plan[13] = '{1, 5'd0, tqprs_pkg::ACT_LAND_REQ, 200, 16'd7, 8'd5,
			1, tqprs_pkg::ST_REFUSED, 0, 0};
		plan[14] = '{0, 0, tqprs_pkg::ACT_TAKEOFF_REQ, 201, 16'd8, 8'd0,
			1, tqprs_pkg::ST_REFUSED, 0, 0};
		plan[15] = '{0, 0, tqprs_pkg::ACT_TICK, 202, 0, 0,
			1, tqprs_pkg::ST_IDLE, 0, 0};
		plan[16] = '{1, 5'd1, tqprs_pkg::ACT_LAND_REQ, 300, 16'd1, 8'd9,
			1, tqprs_pkg::ST_ACCEPTED, 0, 0};
		plan[17] = '{0, 0, tqprs_pkg::ACT_LAND_REQ, 301, 16'd2, 8'd9,
			1, tqprs_pkg::ST_REFUSED, 0, 0};
		plan[18] = '{0, 0, tqprs_pkg::ACT_TAKEOFF_REQ, 302, 16'd3, 8'd0,
			1, tqprs_pkg::ST_ACCEPTED, 0, 0};
		plan[19] = '{0, 0, tqprs_pkg::ACT_TAKEOFF_REQ, 303, 16'd4, 8'd0,
			1, tqprs_pkg::ST_REFUSED, 0, 0};
		plan[20] = '{0, 0, tqprs_pkg::ACT_TICK, 310, 0, 0,
			1, tqprs_pkg::ST_LANDED, 16'd1, 10};
		plan[21] = '{0, 0, tqprs_pkg::ACT_TICK, 320, 0, 0,
			1, tqprs_pkg::ST_TOOKOFF, 16'd3, 18};
		plan[22] = '{1, 5'd31, tqprs_pkg::ACT_LAND_REQ, 400, 16'h8000, 8'h80,
			0, 0, 0, 0};
		plan[23] = '{0, 0, tqprs_pkg::ACT_TICK, 450, 0, 0,
			0, 0, 0, 0};
	end

	// Main sequence: reset, directed table, random phases, drain, verdict
	initial begin
		int   regime;
		logic [4:0] phase_limit;
		clock_base = $urandom;
		regime = 2;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		for (int i = 0; i < N_ROWS; i++) begin
			if (plan[i].cfg_we)
				write_limit(plan[i].cfg_val);
			send_beat(plan[i].act, plan[i].t, plan[i].flight, plan[i].fuel,
				plan[i].typed, plan[i].st, plan[i].served, plan[i].wt);
		end

		// Random phases, each under its own occupancy limit
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: phase_limit = 5'd31;
				1: phase_limit = 5'd16;
				2: phase_limit = 5'd0;
				3: phase_limit = 5'd1;
				4: phase_limit = 5'($urandom_range(15, 2));
				5: phase_limit = 5'($urandom);
				default: phase_limit = 5'd16;
			endcase
			write_limit(phase_limit);
			idle_on = (p != 3);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (k % 40 == 0)
					regime = $urandom_range(2);
				// Back up the block with a long receiver hold-off
				if (p == 1 && k == 60)
					rx_hold_req = 1'b1;
				// Pause the sender until every result is back
				if (p == 5 && k == 110)
					finish_results();
				send_random(regime);
			end
		end

		finish_results();
		repeat (5) @(posedge clk);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
